### rtl/core/pidc_pkg.sv
// shared constants, types and helpers for the drive pid position controller
package pidc_pkg;

	// field widths
	localparam int ENCODER_WIDTH = 24;
	localparam int GAIN_FRACTION_BITS = 8;
	localparam int DIR_W = 3;
	localparam int TARGET_W = 20;
	localparam int MAXP_W = 7;
	localparam int WAIT_W = 16;
	localparam int GAIN_W = 8;
	localparam int ZONE_W = 16;
	localparam int GYRO_W = 16;
	localparam int ELAPSED_W = 10;
	localparam int WHEEL_W = 8;
	localparam int ERR_W = 25;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	// internal widths
	localparam int DIFF_W = ERR_W + 1;
	localparam int INTEG_W = 6;
	localparam int SETTLE_W = 16;
	localparam int AVG_W = ENCODER_WIDTH - 1;
	localparam int GMAG_W = GYRO_W + 1;
	localparam int RAW_W = ((ENCODER_WIDTH > TARGET_W) ? ENCODER_WIDTH : TARGET_W) + 2;
	localparam int CMP_W = (RAW_W > DIFF_W) ? RAW_W : DIFF_W;
	localparam int KP_W = ERR_W + GAIN_W + 1;
	localparam int KI_W = INTEG_W + GAIN_W + 1;
	localparam int KD_W = DIFF_W + GAIN_W + 1;
	localparam int SUM_W = KD_W + 1;
	localparam int PMAG_W = SUM_W - GAIN_FRACTION_BITS;
	localparam int SHAPE_W = 8;
	localparam int MIX_W = GYRO_W + 2;

	// error saturation bounds in the wide compare width
	localparam logic signed [CMP_W-1:0] ERR_HI = CMP_W'((2 ** (ERR_W - 1)) - 1);
	localparam logic signed [CMP_W-1:0] ERR_LO = -ERR_HI - CMP_W'(1);

	// control constants
	localparam int INTEGRAL_LIMIT = 20;
	localparam int STRAIGHT_MIN_POWER = 20;
	localparam int TURN_OFFSET = 15;
	localparam int SETTLE_BAND = 100;
	localparam int STRAFE_DEADBAND = 5;
	localparam int MIN_WAIT_MS = 250;
	localparam int WHEEL_LIMIT = 127;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_NORTH = 3'd0;
	localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
	localparam logic [DIR_W-1:0] DIR_EAST = 3'd4;
	localparam logic [DIR_W-1:0] DIR_WEST = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE = 3'd7;

	// configuration register file contents
	typedef struct packed {
		logic [DIR_W-1:0]    dir;
		logic [TARGET_W-1:0] target;
		logic [MAXP_W-1:0]   max_power;
		logic [WAIT_W-1:0]   wait_ms;
		logic [GAIN_W-1:0]   kp;
		logic [GAIN_W-1:0]   ki;
		logic [GAIN_W-1:0]   kd;
		logic [ZONE_W-1:0]   zone;
	} cfg_t;

	// error stage result handed to the multiply stage
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DIFF_W-1:0]  diff;
		logic                      err_zero;
		logic                      done;
	} track_t;

	// four mixed wheel commands
	typedef struct packed {
		logic signed [WHEEL_W-1:0] fl;
		logic signed [WHEEL_W-1:0] fr;
		logic signed [WHEEL_W-1:0] bl;
		logic signed [WHEEL_W-1:0] br;
	} wheels_t;

	function automatic logic is_turn(input logic [DIR_W-1:0] dir);
		return (dir == DIR_LEFT) || (dir == DIR_RIGHT);
	endfunction

	function automatic logic is_strafe(input logic [DIR_W-1:0] dir);
		return (dir == DIR_EAST) || (dir == DIR_WEST);
	endfunction

	// clip a mixed wheel value to the motor command range
	function automatic logic signed [WHEEL_W-1:0] sat_wheel(input logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] res;
		if (v > $signed(MIX_W'(WHEEL_LIMIT))) begin
			res = $signed(MIX_W'(WHEEL_LIMIT));
		end else if (v < -$signed(MIX_W'(WHEEL_LIMIT))) begin
			res = -$signed(MIX_W'(WHEEL_LIMIT));
		end else begin
			res = v;
		end
		return res[WHEEL_W-1:0];
	endfunction

endpackage

### rtl/core/drive_pid_position_controller.sv
// top level of the drive pid position controller: config registers and pipeline
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | start_move, encoder sums, gyro, elapsed
//  out     | output    | out_valid / out_stall  | four wheel powers, control_error, move_done
//  cfg     | input     | cfg_wr_en              | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_stall is low; after the input register an item passes the
// error, multiply, sum and shape stages into the result register. the loop state updates
// as an item leaves the input register, so items follow back to back. reset clears the
// loop state and loads the register defaults.
// a stalled output holds its item; each stage still fills while a later one is empty.
module drive_pid_position_controller import pidc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        start_move,
	input  logic [ENCODER_WIDTH-1:0]    left_encoder_sum,
	input  logic [ENCODER_WIDTH-1:0]    right_encoder_sum,
	input  logic signed [GYRO_W-1:0]    gyro_reading,
	input  logic [ELAPSED_W-1:0]        elapsed_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WHEEL_W-1:0]   front_left_power,
	output logic signed [WHEEL_W-1:0]   front_right_power,
	output logic signed [WHEEL_W-1:0]   back_left_power,
	output logic signed [WHEEL_W-1:0]   back_right_power,
	output logic signed [ERR_W-1:0]     control_error,
	output logic                        move_done
);

	cfg_t cfg_q;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_out;

	// stage 1: input register
	logic                       start_s1;
	logic [ENCODER_WIDTH-1:0]   left_s1;
	logic [ENCODER_WIDTH-1:0]   right_s1;
	logic signed [GYRO_W-1:0]   gyro_s1;
	logic [ELAPSED_W-1:0]       elapsed_s1;

	// stage 2: error stage result
	track_t                     trk;
	track_t                     trk_s2;
	logic signed [GYRO_W-1:0]   gyro_s2;

	// stage 3: products
	logic signed [KP_W-1:0]     kp_prod;
	logic signed [KI_W-1:0]     ki_prod;
	logic signed [KD_W-1:0]     kd_prod;
	logic signed [KP_W-1:0]     kp_s3;
	logic signed [KI_W-1:0]     ki_s3;
	logic signed [KD_W-1:0]     kd_s3;
	logic signed [ERR_W-1:0]    err_s3;
	logic signed [GYRO_W-1:0]   gyro_s3;
	logic                       done_s3;

	// stage 4: power before shaping
	logic signed [SUM_W-1:0]    pid_sum;
	logic [SUM_W-1:0]           sum_mag;
	logic                       p_neg_s4;
	logic [PMAG_W-1:0]          p_mag_s4;
	logic signed [ERR_W-1:0]    err_s4;
	logic signed [GYRO_W-1:0]   gyro_s4;
	logic                       done_s4;

	wheels_t                    wheels;
	wheels_t                    wheels_q;
	logic signed [ERR_W-1:0]    err_q;
	logic                       done_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dir <= DIR_NORTH;
			cfg_q.target <= '0;
			cfg_q.max_power <= MAXP_W'(127);
			cfg_q.wait_ms <= WAIT_W'(MIN_WAIT_MS);
			cfg_q.kp <= GAIN_W'(51);
			cfg_q.ki <= GAIN_W'(26);
			cfg_q.kd <= GAIN_W'(102);
			cfg_q.zone <= ZONE_W'(210);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DIRECTION: cfg_q.dir <= cfg_wdata[DIR_W-1:0];
				REG_TARGET:    cfg_q.target <= cfg_wdata[TARGET_W-1:0];
				REG_MAX_POWER: cfg_q.max_power <= cfg_wdata[MAXP_W-1:0];
				REG_WAIT_TIME: cfg_q.wait_ms <= cfg_wdata[WAIT_W-1:0];
				REG_KP:        cfg_q.kp <= cfg_wdata[GAIN_W-1:0];
				REG_KI:        cfg_q.ki <= cfg_wdata[GAIN_W-1:0];
				REG_KD:        cfg_q.kd <= cfg_wdata[GAIN_W-1:0];
				REG_ZONE:      cfg_q.zone <= cfg_wdata[ZONE_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// a stage loads when it is empty or the next one takes its item
	always_comb begin
		ld_out = !out_valid_q || !out_stall;
		ld_s4 = !v_s4 || ld_out;
		ld_s3 = !v_s3 || ld_s4;
		ld_s2 = !v_s2 || ld_s3;
		ld_s1 = !v_s1 || ld_s2;
		in_stall = !ld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_out) out_valid_q <= v_s4;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			start_s1 <= start_move;
			left_s1 <= left_encoder_sum;
			right_s1 <= right_encoder_sum;
			gyro_s1 <= gyro_reading;
			elapsed_s1 <= elapsed_ms;
		end
	end

	// error, integral and settle logic; state commits as the item moves on
	pidc_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (v_s1 && ld_s2),
		.cfg     (cfg_q),
		.start   (start_s1),
		.left    (left_s1),
		.right   (right_s1),
		.gyro    (gyro_s1),
		.elapsed (elapsed_s1),
		.trk     (trk)
	);

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			trk_s2 <= trk;
			gyro_s2 <= gyro_s1;
		end
	end

	// gain products, derivative term dropped at zero error
	always_comb begin
		kp_prod = KP_W'($signed({1'b0, cfg_q.kp})) * KP_W'(trk_s2.err);
		ki_prod = KI_W'($signed({1'b0, cfg_q.ki})) * KI_W'(trk_s2.integ);
		kd_prod = trk_s2.err_zero ? '0
			: KD_W'($signed({1'b0, cfg_q.kd})) * KD_W'(trk_s2.diff);
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			kp_s3 <= kp_prod;
			ki_s3 <= ki_prod;
			kd_s3 <= kd_prod;
			err_s3 <= trk_s2.err;
			gyro_s3 <= gyro_s2;
			done_s3 <= trk_s2.done;
		end
	end

	// pid sum, scaled down with truncation toward zero
	always_comb begin
		pid_sum = SUM_W'(kp_s3) + SUM_W'(ki_s3) + SUM_W'(kd_s3);
		sum_mag = pid_sum[SUM_W-1] ? SUM_W'(-pid_sum) : SUM_W'(pid_sum);
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			p_neg_s4 <= pid_sum[SUM_W-1];
			p_mag_s4 <= sum_mag[SUM_W-1:GAIN_FRACTION_BITS];
			err_s4 <= err_s3;
			gyro_s4 <= gyro_s3;
			done_s4 <= done_s3;
		end
	end

	pidc_shape u_shape (
		.cfg    (cfg_q),
		.p_neg  (p_neg_s4),
		.p_mag  (p_mag_s4),
		.gyro   (gyro_s4),
		.done   (done_s4),
		.wheels (wheels)
	);

	// result register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			wheels_q <= wheels;
			err_q <= err_s4;
			done_q <= done_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign front_left_power = wheels_q.fl;
	assign front_right_power = wheels_q.fr;
	assign back_left_power = wheels_q.bl;
	assign back_right_power = wheels_q.br;
	assign control_error = err_q;
	assign move_done = done_q;

endmodule

### rtl/core/pidc_track.sv
// error, integral, derivative difference and settle timer with the loop state registers
module pidc_track import pidc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        commit,
	input  cfg_t                        cfg,
	input  logic                        start,
	input  logic [ENCODER_WIDTH-1:0]    left,
	input  logic [ENCODER_WIDTH-1:0]    right,
	input  logic signed [GYRO_W-1:0]    gyro,
	input  logic [ELAPSED_W-1:0]        elapsed,
	output track_t                      trk
);

	logic signed [INTEG_W-1:0] integral_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic                      armed_q;
	logic [SETTLE_W-1:0]       settle_q;

	logic signed [INTEG_W-1:0] integ_eff;
	logic signed [ERR_W-1:0]   prev_eff;
	logic                      armed_eff;
	logic [SETTLE_W-1:0]       settle_eff;
	logic [ELAPSED_W-1:0]      elapsed_eff;

	logic                      turn;
	logic                      strafe;
	logic                      bad_dir;
	logic [ENCODER_WIDTH:0]    enc_sum;
	logic [AVG_W-1:0]          enc_avg;
	logic signed [GMAG_W-1:0]  gyro_ext;
	logic [GMAG_W-1:0]         gyro_mag;
	logic [CMP_W-1:0]          sub_val;
	logic signed [CMP_W-1:0]   err_raw;
	logic signed [ERR_W-1:0]   err;
	logic [ERR_W-1:0]          err_mag;
	logic                      integ_en;
	logic signed [DIFF_W-1:0]  isum;
	logic signed [INTEG_W-1:0] integ;
	logic signed [DIFF_W-1:0]  diff;
	logic                      armed_nx;
	logic [SETTLE_W:0]         settle_add;
	logic [SETTLE_W-1:0]       settle_sat;
	logic [SETTLE_W-1:0]       settle_nx;
	logic [SETTLE_W-1:0]       wait_eff;
	logic                      done;

	// start of a move clears the loop state for this item
	always_comb begin
		integ_eff = start ? '0 : integral_q;
		prev_eff = start ? '0 : prev_err_q;
		armed_eff = start ? 1'b0 : armed_q;
		settle_eff = start ? '0 : settle_q;
		elapsed_eff = start ? '0 : elapsed;
	end

	// position or heading error, saturated to the error field
	always_comb begin
		turn = is_turn(cfg.dir);
		strafe = is_strafe(cfg.dir);
		bad_dir = cfg.dir > DIR_WEST;
		enc_sum = {1'b0, left} + {1'b0, right};
		enc_avg = enc_sum[ENCODER_WIDTH:2];
		gyro_ext = GMAG_W'(gyro);
		gyro_mag = gyro_ext[GMAG_W-1] ? GMAG_W'(-gyro_ext) : GMAG_W'(gyro_ext);
		sub_val = turn ? CMP_W'(gyro_mag) : CMP_W'(enc_avg);
		err_raw = $signed(CMP_W'(cfg.target)) - $signed(sub_val);
		if (err_raw > ERR_HI) begin
			err = ERR_HI[ERR_W-1:0];
		end else if (err_raw < ERR_LO) begin
			err = ERR_LO[ERR_W-1:0];
		end else begin
			err = err_raw[ERR_W-1:0];
		end
		err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	end

	// integral inside the zone, clamped
	always_comb begin
		integ_en = (err_mag < ERR_W'(cfg.zone)) &&
			(strafe ? (err > $signed(ERR_W'(STRAFE_DEADBAND))) : (err != '0));
		isum = DIFF_W'(integ_eff) + DIFF_W'(err);
		if (!integ_en) begin
			integ = '0;
		end else if (isum > $signed(DIFF_W'(INTEGRAL_LIMIT))) begin
			integ = INTEG_W'(INTEGRAL_LIMIT);
		end else if (isum < -$signed(DIFF_W'(INTEGRAL_LIMIT))) begin
			integ = -INTEG_W'(INTEGRAL_LIMIT);
		end else begin
			integ = isum[INTEG_W-1:0];
		end
		diff = DIFF_W'(err) - DIFF_W'(prev_eff);
	end

	// settle timer
	always_comb begin
		armed_nx = armed_eff || (err < $signed(ERR_W'(SETTLE_BAND)));
		settle_add = (SETTLE_W + 1)'(settle_eff) + (SETTLE_W + 1)'(elapsed_eff);
		settle_sat = settle_add[SETTLE_W] ? '1 : settle_add[SETTLE_W-1:0];
		settle_nx = armed_nx ? settle_sat : '0;
		wait_eff = (cfg.wait_ms < WAIT_W'(MIN_WAIT_MS)) ? WAIT_W'(MIN_WAIT_MS) : cfg.wait_ms;
		done = settle_nx >= wait_eff;
	end

	// stage result; an unknown direction means no move
	always_comb begin
		trk.err = bad_dir ? '0 : err;
		trk.integ = integ;
		trk.diff = diff;
		trk.err_zero = err == '0;
		trk.done = bad_dir ? 1'b1 : done;
	end

	// loop state, updated once per item as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
			armed_q <= 1'b0;
			settle_q <= '0;
		end else if (commit) begin
			if (bad_dir) begin
				integral_q <= integ_eff;
				prev_err_q <= prev_eff;
				armed_q <= armed_eff;
				settle_q <= settle_eff;
			end else begin
				integral_q <= integ;
				prev_err_q <= err;
				armed_q <= armed_nx;
				settle_q <= settle_nx;
			end
		end
	end

endmodule

### rtl/core/pidc_shape.sv
// power shaping, drift correction and four-wheel mixing
module pidc_shape import pidc_pkg::*; (
	input  cfg_t                      cfg,
	input  logic                      p_neg,
	input  logic [PMAG_W-1:0]         p_mag,
	input  logic signed [GYRO_W-1:0]  gyro,
	input  logic                      done,
	output wheels_t                   wheels
);

	logic                     straight;
	logic [SHAPE_W-1:0]       mag;
	logic signed [MIX_W-1:0]  p;
	logic signed [MIX_W-1:0]  d;
	logic signed [MIX_W-1:0]  fl;
	logic signed [MIX_W-1:0]  fr;
	logic signed [MIX_W-1:0]  bl;
	logic signed [MIX_W-1:0]  br;

	// limit, minimum or offset on the power magnitude
	always_comb begin
		straight = !is_turn(cfg.dir) && !is_strafe(cfg.dir);
		if (p_mag > PMAG_W'(cfg.max_power)) begin
			mag = SHAPE_W'(cfg.max_power);
		end else if (p_mag == '0) begin
			mag = '0;
		end else if (straight) begin
			mag = (p_mag < PMAG_W'(STRAIGHT_MIN_POWER)) ? SHAPE_W'(STRAIGHT_MIN_POWER)
				: p_mag[SHAPE_W-1:0];
		end else begin
			mag = p_mag[SHAPE_W-1:0] + SHAPE_W'(TURN_OFFSET);
		end
		p = p_neg ? -$signed(MIX_W'(mag)) : $signed(MIX_W'(mag));
		d = is_turn(cfg.dir) ? '0 : MIX_W'(gyro);
	end

	// wheel mix per direction
	always_comb begin
		case (cfg.dir)
			DIR_NORTH: begin
				fl = p - d; bl = p - d; fr = p + d; br = p + d;
			end
			DIR_SOUTH: begin
				fl = -p - d; bl = -p - d; fr = -p + d; br = -p + d;
			end
			DIR_LEFT: begin
				fl = -p; bl = -p; fr = p; br = p;
			end
			DIR_RIGHT: begin
				fl = p; bl = p; fr = -p; br = -p;
			end
			DIR_EAST: begin
				fl = p - d; fr = -p + d; bl = -p - d; br = p + d;
			end
			DIR_WEST: begin
				fl = -p - d; fr = p + d; bl = p - d; br = -p + d;
			end
			default: begin
				fl = '0; fr = '0; bl = '0; br = '0;
			end
		endcase
	end

	// motors stop once the move is done
	always_comb begin
		wheels.fl = done ? '0 : sat_wheel(fl);
		wheels.fr = done ? '0 : sat_wheel(fr);
		wheels.bl = done ? '0 : sat_wheel(bl);
		wheels.br = done ? '0 : sat_wheel(br);
	end

endmodule

### tb/sv/drive_cmd_board_pkg.sv
// expected wheel command model and result checker for the pid controller testbench
package drive_cmd_board_pkg;
	import pidc_pkg::*;

	// one wheel command result as seen on the output channel
	typedef struct packed {
		logic signed [WHEEL_W-1:0] fl;
		logic signed [WHEEL_W-1:0] fr;
		logic signed [WHEEL_W-1:0] bl;
		logic signed [WHEEL_W-1:0] br;
		logic signed [ERR_W-1:0]   err;
		logic                      done;
	} drive_cmd_t;

	localparam longint ERR_TOP = (longint'(1) << (ERR_W - 1)) - 1;
	localparam longint ERR_BOT = -ERR_TOP - 1;
	localparam longint SETTLE_TOP = (longint'(1) << SETTLE_W) - 1;
	localparam int SHOW_LIMIT = 40;

	class drive_cmd_board;
		// register copies
		logic [DIR_W-1:0]    dir;
		logic [TARGET_W-1:0] target;
		logic [MAXP_W-1:0]   maxp;
		logic [WAIT_W-1:0]   wait_ms;
		logic [GAIN_W-1:0]   kp;
		logic [GAIN_W-1:0]   ki;
		logic [GAIN_W-1:0]   kd;
		logic [ZONE_W-1:0]   zone;

		// loop state copies
		longint integ_acc;
		longint prev_err;
		bit     armed;
		longint settle_ms;

		drive_cmd_t expected_cmds[$];
		int mismatches;

		function new();
			dir = DIR_NORTH;
			target = '0;
			maxp = MAXP_W'(WHEEL_LIMIT);
			wait_ms = WAIT_W'(MIN_WAIT_MS);
			kp = 8'd51;
			ki = 8'd26;
			kd = 8'd102;
			zone = 16'd210;
			integ_acc = 0;
			prev_err = 0;
			armed = 1'b0;
			settle_ms = 0;
			mismatches = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_DIRECTION: dir = val[DIR_W-1:0];
				REG_TARGET:    target = val[TARGET_W-1:0];
				REG_MAX_POWER: maxp = val[MAXP_W-1:0];
				REG_WAIT_TIME: wait_ms = val[WAIT_W-1:0];
				REG_KP:        kp = val[GAIN_W-1:0];
				REG_KI:        ki = val[GAIN_W-1:0];
				REG_KD:        kd = val[GAIN_W-1:0];
				default:       zone = val[ZONE_W-1:0];
			endcase
		endfunction

		function logic signed [WHEEL_W-1:0] clip_wheel(input longint v);
			if (v > WHEEL_LIMIT) v = WHEEL_LIMIT;
			else if (v < -WHEEL_LIMIT) v = -WHEEL_LIMIT;
			return WHEEL_W'(v);
		endfunction

		// work out the command that one accepted control tick produces
		function void note_tick(input logic st, input logic [ENCODER_WIDTH-1:0] l,
				input logic [ENCODER_WIDTH-1:0] r, input logic signed [GYRO_W-1:0] g,
				input logic [ELAPSED_W-1:0] el);
			longint e, mag_e, gy, integ, deriv, s, p, pm, sp, d, fl, fr, bl, br, step_ms, hold;
			bit turn, strafe, done;
			drive_cmd_t cmd;
			step_ms = el;
			gy = g;

			// a new move clears the loop state and ignores this tick's time
			if (st) begin
				integ_acc = 0;
				prev_err = 0;
				armed = 1'b0;
				settle_ms = 0;
				step_ms = 0;
			end

			// unknown direction: no move, state untouched
			if (dir > DIR_WEST) begin
				cmd = '0;
				cmd.done = 1'b1;
				expected_cmds.push_back(cmd);
				return;
			end

			turn = (dir == DIR_LEFT) || (dir == DIR_RIGHT);
			strafe = (dir == DIR_EAST) || (dir == DIR_WEST);

			// error term
			if (turn) e = longint'(target) - ((gy < 0) ? -gy : gy);
			else e = longint'(target) - ((longint'(l) + longint'(r)) >>> 2);
			if (e > ERR_TOP) e = ERR_TOP;
			else if (e < ERR_BOT) e = ERR_BOT;
			mag_e = (e < 0) ? -e : e;

			// integral inside the zone only
			if ((mag_e < longint'(zone)) && (strafe ? (e > STRAFE_DEADBAND) : (e != 0))) begin
				integ = integ_acc + e;
				if (integ > INTEGRAL_LIMIT) integ = INTEGRAL_LIMIT;
				else if (integ < -INTEGRAL_LIMIT) integ = -INTEGRAL_LIMIT;
			end else begin
				integ = 0;
			end
			integ_acc = integ;

			deriv = (e == 0) ? 0 : longint'(kd) * (e - prev_err);
			prev_err = e;

			// pid sum, truncated toward zero
			s = longint'(kp) * e + longint'(ki) * integ + deriv;
			p = (s < 0) ? -((-s) >>> GAIN_FRACTION_BITS) : (s >>> GAIN_FRACTION_BITS);

			// power shaping
			pm = (p < 0) ? -p : p;
			sp = (p > 0) ? 1 : ((p < 0) ? -1 : 0);
			if (pm > longint'(maxp)) p = sp * longint'(maxp);
			else if (!turn && !strafe) begin
				if (pm < STRAIGHT_MIN_POWER) p = sp * STRAIGHT_MIN_POWER;
			end else begin
				p = sp * (pm + TURN_OFFSET);
			end

			// drift correction and wheel mixing
			d = turn ? 0 : gy;
			case (dir)
				DIR_NORTH: begin fl = p - d; bl = p - d; fr = p + d; br = p + d; end
				DIR_SOUTH: begin fl = -p - d; bl = -p - d; fr = -p + d; br = -p + d; end
				DIR_LEFT:  begin fl = -p; bl = -p; fr = p; br = p; end
				DIR_RIGHT: begin fl = p; bl = p; fr = -p; br = -p; end
				DIR_EAST:  begin fl = p - d; fr = -p + d; bl = -p - d; br = p + d; end
				default:   begin fl = -p - d; fr = p + d; bl = p - d; br = -p + d; end
			endcase

			// settle timer
			if (e < SETTLE_BAND) armed = 1'b1;
			if (armed) begin
				settle_ms = settle_ms + step_ms;
				if (settle_ms > SETTLE_TOP) settle_ms = SETTLE_TOP;
			end else begin
				settle_ms = 0;
			end
			hold = (wait_ms < MIN_WAIT_MS) ? MIN_WAIT_MS : longint'(wait_ms);
			done = settle_ms >= hold;
			if (done) begin
				fl = 0;
				fr = 0;
				bl = 0;
				br = 0;
			end

			cmd.fl = clip_wheel(fl);
			cmd.fr = clip_wheel(fr);
			cmd.bl = clip_wheel(bl);
			cmd.br = clip_wheel(br);
			cmd.err = e[ERR_W-1:0];
			cmd.done = done;
			expected_cmds.push_back(cmd);
		endfunction

		function void diff_field(input string name, input logic signed [31:0] want,
				input logic signed [31:0] got);
			if (got !== want) begin
				if (mismatches < SHOW_LIMIT)
					$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// compare one output item against the oldest expected command
		function void check_cmd(input drive_cmd_t got);
			drive_cmd_t want;
			if (expected_cmds.size() == 0) begin
				if (mismatches < SHOW_LIMIT)
					$display("%0t: result with nothing pending, expected none, got error %0d",
						$time, got.err);
				mismatches++;
				return;
			end
			want = expected_cmds.pop_front();
			diff_field("front_left_power", want.fl, got.fl);
			diff_field("front_right_power", want.fr, got.fr);
			diff_field("back_left_power", want.bl, got.bl);
			diff_field("back_right_power", want.br, got.br);
			diff_field("control_error", want.err, got.err);
			diff_field("move_done", want.done, got.done);
		endfunction
	endclass

endpackage

### tb/sv/tb_drive_pid_position_controller.sv
// top-level testbench for the drive pid position controller
module tb_drive_pid_position_controller;
	import pidc_pkg::*;
	import drive_cmd_board_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam longint ENC_TOP = (longint'(1) << ENCODER_WIDTH) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic start_move = 1'b0;
	logic [ENCODER_WIDTH-1:0] left_encoder_sum = '0;
	logic [ENCODER_WIDTH-1:0] right_encoder_sum = '0;
	logic signed [GYRO_W-1:0] gyro_reading = '0;
	logic [ELAPSED_W-1:0] elapsed_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [WHEEL_W-1:0] front_left_power;
	logic signed [WHEEL_W-1:0] front_right_power;
	logic signed [WHEEL_W-1:0] back_left_power;
	logic signed [WHEEL_W-1:0] back_right_power;
	logic signed [ERR_W-1:0] control_error;
	logic move_done;

	drive_cmd_board board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [DIR_W-1:0] cur_dir = DIR_NORTH;
	logic [TARGET_W-1:0] cur_target = '0;

	drive_pid_position_controller u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.start_move        (start_move),
		.left_encoder_sum  (left_encoder_sum),
		.right_encoder_sum (right_encoder_sum),
		.gyro_reading      (gyro_reading),
		.elapsed_ms        (elapsed_ms),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.front_left_power  (front_left_power),
		.front_right_power (front_right_power),
		.back_left_power   (back_left_power),
		.back_right_power  (back_right_power),
		.control_error     (control_error),
		.move_done         (move_done)
	);

	// clock
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// hard stop
	initial begin
		#(CLK_PERIOD * 400000);
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: check accepted items, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_cmd(drive_cmd_t'{front_left_power, front_right_power, back_left_power,
				back_right_power, control_error, move_done});
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// present one control tick and wait until it is taken
	task automatic send_tick(input logic st, input logic [ENCODER_WIDTH-1:0] l,
			input logic [ENCODER_WIDTH-1:0] r, input logic signed [GYRO_W-1:0] g,
			input logic [ELAPSED_W-1:0] el);
		int gap;
		gap = 0;
		while ((gap < 12) && ($urandom_range(99) < send_idle_pct)) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_move <= st;
		left_encoder_sum <= l;
		right_encoder_sum <= r;
		gyro_reading <= g;
		elapsed_ms <= el;
		do @(posedge clk); while (in_stall);
		board.note_tick(st, l, r, g, el);
	endtask

	// let every pending command come out, then let the pipeline idle before returning
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.expected_cmds.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write the whole register set while the block is idle
	task automatic load_regs(input logic [DIR_W-1:0] dir, input logic [TARGET_W-1:0] target,
			input logic [MAXP_W-1:0] maxp, input logic [WAIT_W-1:0] wait_ms,
			input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
			input logic [GAIN_W-1:0] kd, input logic [ZONE_W-1:0] zone);
		logic [CFG_DATA_W-1:0] vals [8];
		int i;
		wait_idle();
		vals[REG_DIRECTION] = CFG_DATA_W'(dir);
		vals[REG_TARGET] = CFG_DATA_W'(target);
		vals[REG_MAX_POWER] = CFG_DATA_W'(maxp);
		vals[REG_WAIT_TIME] = CFG_DATA_W'(wait_ms);
		vals[REG_KP] = CFG_DATA_W'(kp);
		vals[REG_KI] = CFG_DATA_W'(ki);
		vals[REG_KD] = CFG_DATA_W'(kd);
		vals[REG_ZONE] = CFG_DATA_W'(zone);
		for (i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			board.set_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_wr_en <= 1'b0;
		cur_dir = dir;
		cur_target = target;
	endtask

	// a move: error walks from the target toward zero with noise and overshoot
	task automatic run_move(input int ticks);
		int k;
		longint e_want, pos, sum, lo, hi, mag;
		logic [ENCODER_WIDTH-1:0] l, r;
		logic signed [GYRO_W-1:0] g;
		logic [ELAPSED_W-1:0] el;
		logic st;
		for (k = 0; k < ticks; k++) begin
			if ($urandom_range(5) == 0) e_want = longint'($urandom_range(12)) - 6;
			else e_want = longint'(cur_target) * (ticks - 1 - k) / ticks
				+ longint'($urandom_range(60)) - 30;
			el = ($urandom_range(9) == 0) ? ELAPSED_W'($urandom) : ELAPSED_W'($urandom_range(25, 15));
			st = (k == 0) && ($urandom_range(4) != 0);
			if ((cur_dir == DIR_LEFT) || (cur_dir == DIR_RIGHT)) begin
				// heading sweeps toward the target, either sign
				mag = longint'(cur_target) - e_want;
				if (mag < 0) mag = 0;
				if (mag > 32767) mag = 32767;
				g = ($urandom_range(1) == 1) ? GYRO_W'(-mag) : GYRO_W'(mag);
				l = ENCODER_WIDTH'($urandom);
				r = ENCODER_WIDTH'($urandom);
			end else begin
				// encoder sums split at random between the two sides
				pos = longint'(cur_target) - e_want;
				if (pos < 0) pos = 0;
				sum = pos * 4 + longint'($urandom_range(3));
				if (sum > 2 * ENC_TOP) sum = 2 * ENC_TOP;
				lo = (sum > ENC_TOP) ? sum - ENC_TOP : 0;
				hi = (sum > ENC_TOP) ? ENC_TOP : sum;
				l = ENCODER_WIDTH'(lo + longint'($urandom_range(32'(hi - lo))));
				r = ENCODER_WIDTH'(sum - longint'(l));
				g = ($urandom_range(9) == 0) ? GYRO_W'($urandom)
					: GYRO_W'(longint'($urandom_range(80)) - 40);
			end
			send_tick(st, l, r, g, el);
		end
	endtask

	// stimulus
	initial begin
		int ph, count, n, d;
		logic [DIR_W-1:0] dir;
		logic [TARGET_W-1:0] target;
		logic [MAXP_W-1:0] maxp;
		logic [WAIT_W-1:0] wait_ms;
		logic [GAIN_W-1:0] kp, ki, kd;
		logic [ZONE_W-1:0] zone;
		logic turn;

		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero error, encoder and gyro extremes
		send_tick(1'b1, '0, '0, '0, '0);
		send_tick(1'b0, '1, '1, 16'sh8000, '1);
		send_tick(1'b0, '0, '0, 16'sh7fff, '1);

		// each direction code: far, inside the zone, then settled with a small error
		for (d = 0; d < 8; d++) begin
			dir = DIR_W'(d);
			turn = (dir == DIR_LEFT) || (dir == DIR_RIGHT);
			load_regs(dir, 20'd1000, 7'd127, 16'd250, 8'd51, 8'd26, 8'd102, 16'd210);
			send_tick(1'b1, '0, '0, '0, 10'd500);
			if (turn) send_tick(1'b0, '0, '0, -16'sd850, 10'd100);
			else send_tick(1'b0, 24'd1700, 24'd1700, 16'sd25, 10'd100);
			if (turn) send_tick(1'b0, '0, '0, 16'sd997, 10'd300);
			else send_tick(1'b0, 24'd1994, 24'd1994, -16'sd7, 10'd300);
		end

		// random phases, cycling through the idle patterns
		for (ph = 0; ph < 20; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 67; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 67; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase

			dir = ($urandom_range(15) == 0) ? DIR_W'($urandom_range(7, 6)) : DIR_W'($urandom_range(5));
			if (ph == 0) begin
				// every register at its top
				target = '1; maxp = '1; wait_ms = '1; kp = '1; ki = '1; kd = '1; zone = '1;
			end else if (ph == 1) begin
				// every register at its bottom
				target = '0; maxp = '0; wait_ms = '0; kp = '0; ki = '0; kd = '0; zone = '0;
			end else begin
				if ($urandom_range(7) == 0) target = TARGET_W'($urandom);
				else if ((dir == DIR_LEFT) || (dir == DIR_RIGHT)) target = TARGET_W'($urandom_range(3600));
				else target = TARGET_W'($urandom_range(20000));
				maxp = ($urandom_range(5) == 0) ? ($urandom_range(1) ? '1 : '0) : MAXP_W'($urandom);
				case ($urandom_range(3))
					0: wait_ms = WAIT_W'($urandom_range(249));
					1: wait_ms = WAIT_W'(MIN_WAIT_MS);
					2: wait_ms = WAIT_W'($urandom_range(800, 251));
					default: wait_ms = ($urandom_range(3) == 0) ? '1 : WAIT_W'($urandom);
				endcase
				kp = ($urandom_range(5) == 0) ? ($urandom_range(1) ? '1 : '0) : GAIN_W'($urandom);
				ki = ($urandom_range(5) == 0) ? ($urandom_range(1) ? '1 : '0) : GAIN_W'($urandom);
				kd = ($urandom_range(5) == 0) ? ($urandom_range(1) ? '1 : '0) : GAIN_W'($urandom);
				zone = ($urandom_range(3) == 0) ? ZONE_W'($urandom) : ZONE_W'($urandom_range(400));
			end
			load_regs(dir, target, maxp, wait_ms, kp, ki, kd, zone);

			count = 0;
			while (count < 40) begin
				if ($urandom_range(6) == 0) begin
					// noise item with fully random fields
					send_tick(($urandom_range(7) == 0), ENCODER_WIDTH'($urandom),
						ENCODER_WIDTH'($urandom), GYRO_W'($urandom), ELAPSED_W'($urandom));
					count++;
				end else begin
					n = $urandom_range(16, 4);
					run_move(n);
					count += n;
				end
			end
		end

		wait_idle();
		if (board.mismatches == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
